// ===== rtl/assert_macros.svh =====
// Assertion helpers for the bar aggregator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/ohlc_pkg.sv =====
package ohlc_pkg;
    localparam int NUM_SYMBOLS = 64;
    localparam int SYM_W = 6;
    localparam int ADDR_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam logic [48:0] NONE49 = '1;
    localparam logic [31:0] IV_RESET = 32'd60000;

    localparam logic [2:0] ST_NONE   = 3'd0;
    localparam logic [2:0] ST_BAR    = 3'd1;
    localparam logic [2:0] ST_INVAL  = 3'd2;
    localparam logic [2:0] ST_ORDER  = 3'd3;
    localparam logic [2:0] ST_BADBAR = 3'd4;
    localparam logic [2:0] ST_MIXED  = 3'd5;
    localparam logic [2:0] ST_GAP    = 3'd6;

    typedef struct packed {
        logic [47:0] last_seen_time;
        logic        saw_ticks;
        logic        saw_bars;
        logic [48:0] last_bar_end;
        logic [48:0] current_bucket;
        logic        bucket_full;
        logic [47:0] acc_open;
        logic [47:0] acc_high;
        logic [47:0] acc_low;
        logic [47:0] acc_close;
        logic [47:0] acc_mark;
        logic [63:0] acc_volume;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic t_entry entry_reset();
        t_entry e;
        e = '0;
        e.last_bar_end = NONE49;
        e.current_bucket = NONE49;
        return e;
    endfunction
endpackage

// ===== rtl/ohlc_div.sv =====
// Restoring divider: 48-bit dividend by 32-bit divisor, one quotient bit a cycle.
module ohlc_div
    import ohlc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [47:0] o_quot,
    output logic [31:0] o_rem
);
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [47:0] r_q, n_q;
    logic [32:0] r_r, n_r;
    logic [31:0] r_d;
    logic [32:0] w_sh;
    logic [33:0] w_diff;

    always_comb begin
        w_sh   = {r_r[31:0], r_q[47]};
        w_diff = {1'b0, w_sh} - {2'b0, r_d};
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_q    = r_q;
        n_r    = r_r;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd0;
            n_q    = i_num;
            n_r    = '0;
        end else if (r_busy) begin
            if (!w_diff[33]) begin
                n_r = w_diff[32:0];
                n_q = {r_q[46:0], 1'b1};
            end else begin
                n_r = w_sh;
                n_q = {r_q[46:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd47) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        if (i_start) r_d <= i_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r[31:0];
endmodule

// ===== rtl/ohlc_mem.sv =====
// Symbol table memory with registered read and a per-entry valid bit.
module ohlc_mem
    import ohlc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_entry            o_rdata,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_entry            i_wdata
);
    logic [ENTRY_W-1:0]    r_mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] r_vld;
    logic [ENTRY_W-1:0]    r_rd;
    logic                  r_rv;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rd <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_rv  <= 1'b0;
        end else begin
            if (i_we) r_vld[i_waddr] <= 1'b1;
            r_rv <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rv ? t_entry'(r_rd) : entry_reset();
endmodule

// ===== rtl/tick_to_ohlc_bar_aggregator.sv =====
// Tick to OHLC bar aggregator.
// Input channel s_axis: one item per tick or explicit closed bar; tuser holds
// time_only, is_closed_bar, ohlc_present, tdata the remaining fields.
// Output channel m_axis: exactly one item per input item; tdata carries the
// status and, for status bar, the emitted bar (otherwise zeros).
// Config: i_cfg_we writes bar_interval from i_cfg_wdata (zero acts as one);
// write only while idle.
// Each item: table read and divider start, then the shift-subtract divider
// (time / interval), then update and write-back into the result register.
// The next item is taken only after that write-back, in the idle state; one
// item at a time.
// The next item is taken only while the output register is empty or is being
// read in the same cycle.
// Reset: the per-symbol table reads as cleared (valid bits drop at once),
// interval returns to 60000 ms, no clearing pass.
// Stall: the output register holds; the block takes no new item until the
// waiting result is taken.
`include "assert_macros.svh"
module tick_to_ohlc_bar_aggregator
    import ohlc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // symbol_id[5:0], time_ms[53:6], price[101:54], volume[149:102],
    // mark_px[197:150], item_interval[229:198], open_in[277:230],
    // high_in[325:278], low_in[373:326], zero fill to 376
    input  logic [375:0] s_axis_tdata,
    // time_only[0], is_closed_bar[1], ohlc_present[2]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], bar_symbol[8:3], bar_end_ms[56:9], bar_open_out[104:57],
    // bar_high_out[152:105], bar_low_out[200:153], bar_close_out[248:201],
    // bar_mark_out[296:249], bar_volume_out[360:297], zero fill to 368
    output logic [367:0] m_axis_tdata
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [31:0]  r_iv;
    logic [1:0]   r_st, n_st;
    logic [375:0] r_in;
    logic [2:0]   r_usr;
    t_entry       r_e;
    logic         r_ov, n_ov;
    logic [367:0] r_od, n_od;

    // hold the interval, zero means one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_iv <= IV_RESET;
        else if (i_cfg_we) r_iv <= (i_cfg_wdata == 32'd0) ? 32'd1 : i_cfg_wdata;
    end

    logic [5:0]  w_sym;
    logic [47:0] w_t, w_pr, w_vol, w_mk, w_op, w_hi, w_lo;
    logic [31:0] w_iiv;
    logic        w_ex, w_cb, w_oh;
    assign w_sym = r_in[5:0];
    assign w_t   = r_in[53:6];
    assign w_pr  = r_in[101:54];
    assign w_vol = r_in[149:102];
    assign w_mk  = r_in[197:150];
    assign w_iiv = r_in[229:198];
    assign w_op  = r_in[277:230];
    assign w_hi  = r_in[325:278];
    assign w_lo  = r_in[373:326];
    assign w_ex  = r_usr[0];
    assign w_cb  = r_usr[1];
    assign w_oh  = r_usr[2];

    t_entry w_rd;
    logic   w_we;
    t_entry w_wd;
    logic   w_dstart, w_ddone;
    logic [47:0] w_q;
    logic [31:0] w_rem;

    ohlc_mem u_mem (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_raddr(s_axis_tdata[ADDR_W-1:0]), .o_rdata(w_rd),
        .i_we(w_we), .i_waddr(w_sym[ADDR_W-1:0]), .i_wdata(w_wd)
    );

    ohlc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_t), .i_den(r_iv), .o_done(w_ddone), .o_quot(w_q), .o_rem(w_rem)
    );

    assign s_axis_tready = (r_st == S_IDLE) && (!r_ov || m_axis_tready);
    assign w_dstart = (r_st == S_READ);

    logic [47:0] w_end;
    logic [48:0] w_nxt;
    logic [48:0] w_bk;
    logic [64:0] w_vsum;
    logic [47:0] w_mx, w_mn;
    logic        w_sym_bad;
    // bucket start is the time less its remainder: quotient times interval
    assign w_end  = w_t - {16'd0, w_rem};
    assign w_bk   = {1'b0, w_q};
    assign w_nxt  = r_e.current_bucket + 49'd1;
    assign w_vsum = {1'b0, r_e.acc_volume} + {17'd0, w_vol};
    assign w_mx   = (w_op > w_pr) ? w_op : w_pr;
    assign w_mn   = (w_op < w_pr) ? w_op : w_pr;
    assign w_sym_bad = ({26'd0, w_sym} >= 32'(NUM_SYMBOLS));

    // resolve the item once the quotient and remainder are in
    always_comb begin
        logic [2:0] st;
        logic       bar;
        logic [47:0] bo, bh, bl, bc, bm, be;
        logic [63:0] bv;
        logic       startup;
        t_entry     e;
        e   = r_e;
        st  = ST_NONE;
        bar = 1'b0;
        bo = w_op; bh = w_hi; bl = w_lo; bc = w_pr; bm = w_mk; be = w_t; bv = {16'd0, w_vol};
        w_we = 1'b0;
        startup = (r_e.current_bucket == NONE49);
        if (w_sym_bad || w_t == 48'd0 || w_pr == 48'd0) begin
            st = ST_INVAL;
        end else if (w_t < r_e.last_seen_time) begin
            st = ST_ORDER;
        end else begin
            w_we = 1'b1;
            e.last_seen_time = w_t;
            if (w_ex) begin
                st = ST_NONE;
            end else if (w_cb) begin
                if (r_e.saw_ticks || w_iiv != r_iv || w_rem != 32'd0 ||
                    (r_e.last_bar_end != NONE49 &&
                     {1'b0, w_t} != r_e.last_bar_end + {17'd0, r_iv}) ||
                    !w_oh || w_op == 48'd0 || w_lo == 48'd0 || w_hi < w_mx || w_lo > w_mn)
                begin
                    st = ST_BADBAR;
                end else begin
                    e.saw_bars = 1'b1;
                    e.last_bar_end = {1'b0, w_t};
                    st = ST_BAR;
                    bar = 1'b1;
                end
            end else if (r_e.saw_bars || w_oh) begin
                st = ST_MIXED;
            end else begin
                e.saw_ticks = 1'b1;
                if (w_bk != r_e.current_bucket) begin
                    if (!startup && w_bk != w_nxt) begin
                        st = ST_GAP;
                    end else begin
                        if (!startup && r_e.bucket_full) begin
                            st = ST_BAR; bar = 1'b1;
                            be = w_end;
                            bo = r_e.acc_open; bh = r_e.acc_high; bl = r_e.acc_low;
                            bc = r_e.acc_close; bm = r_e.acc_mark; bv = r_e.acc_volume;
                            e.last_bar_end = {1'b0, w_end};
                        end
                        e.current_bucket = w_bk;
                        e.bucket_full = !startup || (w_rem == 32'd0);
                        e.acc_open = w_pr; e.acc_high = w_pr; e.acc_low = w_pr;
                        e.acc_close = w_pr; e.acc_mark = w_mk; e.acc_volume = {16'd0, w_vol};
                    end
                end else begin
                    e.acc_close = w_pr;
                    e.acc_mark = w_mk;
                    if (w_pr > r_e.acc_high) e.acc_high = w_pr;
                    if (w_pr < r_e.acc_low) e.acc_low = w_pr;
                    e.acc_volume = w_vsum[64] ? '1 : w_vsum[63:0];
                end
            end
        end
        w_we = w_we && w_ddone && (r_st == S_DONE);
        w_wd = e;
        if (bar)
            n_od = {7'd0, bv, bm, bc, bl, bh, bo, be, w_sym, st};
        else
            n_od = {365'd0, st};
    end

    always_comb begin
        n_st = r_st;
        n_ov = r_ov;
        if (m_axis_tready) n_ov = 1'b0;
        unique case (r_st)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) n_st = S_READ;
            S_READ: n_st = S_DIV;
            S_DIV:  n_st = S_DONE;
            S_DONE: if (w_ddone) begin
                n_st = S_IDLE;
                n_ov = 1'b1;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in  <= s_axis_tdata;
            r_usr <= s_axis_tuser;
        end
        if (r_st == S_READ) r_e <= w_rd;
        if (r_st == S_DONE && w_ddone) r_od <= n_od;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;

    `CHK_IMPL(a_ready_idle, i_clk, i_rst_n, s_axis_tready, r_st == S_IDLE)
    `CHK_NEXT(a_accept_read, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_st == S_READ)
    `CHK_IMPL(a_we_done, i_clk, i_rst_n, w_we, r_st == S_DONE && w_ddone)
    `CHK_NEXT(a_done_out, i_clk, i_rst_n, r_st == S_DONE && w_ddone, m_axis_tvalid)
endmodule
